>>> sv/dsq_pkg.sv
// Shared types, constants and helper functions for the delta sleep queue.
// Used by the cell, the controller and the top level; depends on nothing.
package dsq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 16;
    localparam int ID_W        = 8;
    localparam int DUR_W       = 16;
    localparam int MODE_W      = 2;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_SLEEP    = 2'd0,
        MODE_TICK     = 2'd1,
        MODE_REMOVE   = 2'd2,
        MODE_WAKE_ALL = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_DEC,
        CMD_POP,
        CMD_INSERT,
        CMD_DROP
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_WAKE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] delta;
    } t_entry;

    // search token handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 flag;   // insert place or removed entry already seen
        logic                 dup;    // id already queued
        logic [CNT_W-1:0]     rem;    // occupied cells still ahead
        logic [TIME_BITS-1:0] t;      // remaining wait for a sleep item
    } t_token;

    // command broadcast from the controller to every cell
    typedef struct packed {
        t_cmd                 cmd;
        logic                 is_sleep;
        logic [ID_W-1:0]      tid;
        logic [TIME_BITS-1:0] new_t;
    } t_bcast;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    endfunction

    // zero counts as one tick, a too-wide value saturates
    function automatic logic [TIME_BITS-1:0] norm_duration(input logic [DUR_W-1:0] dur);
        logic [DUR_W+TIME_BITS-1:0] wide;
        logic [DUR_W+TIME_BITS-1:0] wmax;
        wide = {{TIME_BITS{1'b0}}, dur};
        wmax = {{DUR_W{1'b0}}, TIME_MAX};
        if (dur == '0) begin
            return {{(TIME_BITS-1){1'b0}}, 1'b1};
        end else if (wide > wmax) begin
            return TIME_MAX;
        end else begin
            return wide[TIME_BITS-1:0];
        end
    endfunction

endpackage

>>> sv/dsq_cell.sv
// One slot of the delta list: holds an id and its delta, processes the
// search token and applies broadcast shift and decrement commands. Depends on dsq_pkg.
module dsq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_first,
    input  dsq_pkg::t_bcast i_bc,
    input  dsq_pkg::t_entry i_left,
    input  logic            i_left_at,
    input  dsq_pkg::t_entry i_right,
    input  dsq_pkg::t_token i_tok,
    output dsq_pkg::t_entry o_entry,
    output logic            o_at,
    output dsq_pkg::t_token o_tok
);
    import dsq_pkg::*;

    t_entry r_entry, n_entry;
    t_token r_tok, n_tok;
    logic   r_at, r_after;

    logic occ, hit, stop, at_here;

    always_comb begin
        occ     = (i_tok.rem != '0);
        hit     = occ && (r_entry.id == i_bc.tid);
        stop    = !occ || (r_entry.delta > i_tok.t);
        at_here = !i_tok.flag && (i_bc.is_sleep ? stop : hit);

        n_tok.valid = i_tok.valid;
        n_tok.flag  = i_tok.flag | at_here;
        n_tok.dup   = i_tok.dup | hit;
        n_tok.rem   = occ ? i_tok.rem - CNT_W'(1) : '0;
        n_tok.t     = (i_bc.is_sleep && !i_tok.flag && !stop) ?
                      i_tok.t - r_entry.delta : i_tok.t;
    end

    always_comb begin
        n_entry = r_entry;
        unique case (i_bc.cmd)
            CMD_HOLD: begin
                n_entry = r_entry;
            end
            CMD_DEC: begin
                if (i_first && r_entry.delta != '0) begin
                    n_entry.delta = r_entry.delta - TIME_BITS'(1);
                end
            end
            CMD_POP: begin
                n_entry = i_right;
            end
            CMD_INSERT: begin
                if (r_at) begin
                    n_entry.id    = i_bc.tid;
                    n_entry.delta = i_bc.new_t;
                end else if (r_after) begin
                    n_entry.id    = i_left.id;
                    // successor of the new entry has the new wait taken off its delta
                    n_entry.delta = i_left_at ? i_left.delta - i_bc.new_t : i_left.delta;
                end
            end
            CMD_DROP: begin
                if (r_at) begin
                    n_entry.id    = i_right.id;
                    n_entry.delta = sat_add(r_entry.delta, i_right.delta);
                end else if (r_after) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_at    <= 1'b0;
            r_after <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_tok.valid) begin
                r_at    <= at_here;
                r_after <= i_tok.flag;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_at    = r_at;
    assign o_tok   = r_tok;

endmodule

>>> sv/dsq_ctrl.sv
// Sequencer of the delta sleep queue: takes items, launches the search
// token, issues shift commands and emits woken ids. Depends on dsq_pkg.
module dsq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dsq_pkg::MODE_W-1:0]    i_mode,
    input  logic [dsq_pkg::ID_W-1:0]      i_proc_id,
    input  logic [dsq_pkg::DUR_W-1:0]     i_duration,
    input  dsq_pkg::t_entry               i_head,
    input  logic [dsq_pkg::TIME_BITS-1:0] i_second_delta,
    input  dsq_pkg::t_token               i_tok_end,
    output logic                          o_busy,
    output dsq_pkg::t_bcast               o_bc,
    output dsq_pkg::t_token               o_tok,
    output logic                          o_valid,
    output logic [dsq_pkg::ID_W-1:0]      o_woken_id,
    output logic                          o_last
);
    import dsq_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count;
    logic                 r_all;
    logic                 r_is_sleep;
    logic [ID_W-1:0]      r_tid;
    logic [TIME_BITS-1:0] r_t;
    logic                 r_tok_valid;
    logic                 r_valid;
    logic [ID_W-1:0]      r_id;
    logic                 r_last;

    t_mode mode;
    t_cmd  cmd;
    logic  accept, full, wake_now, wake_last;

    assign mode      = t_mode'(i_mode);
    assign accept    = i_start && (r_state == ST_IDLE);
    assign full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign wake_now  = (r_count != '0) && (r_all || i_head.delta == '0);
    assign wake_last = (r_count == CNT_W'(1)) || (!r_all && i_second_delta != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (mode)
                        MODE_SLEEP:    n_state = full ? ST_IDLE : ST_WALK;
                        MODE_REMOVE:   n_state = ST_WALK;
                        MODE_TICK:     n_state = (r_count != '0) ? ST_WAKE : ST_IDLE;
                        MODE_WAKE_ALL: n_state = ST_WAKE;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                if (i_tok_end.valid) begin
                    n_state = ST_IDLE;
                end
            end
            ST_WAKE: begin
                if (!wake_now || wake_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = CMD_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && mode == MODE_TICK && r_count != '0) begin
                    cmd = CMD_DEC;
                end
            end
            ST_WALK: begin
                if (i_tok_end.valid) begin
                    if (r_is_sleep && !i_tok_end.dup) begin
                        cmd = CMD_INSERT;
                    end else if (!r_is_sleep && i_tok_end.flag) begin
                        cmd = CMD_DROP;
                    end
                end
            end
            ST_WAKE: begin
                if (wake_now) begin
                    cmd = CMD_POP;
                end
            end
            default: cmd = CMD_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id   <= i_head.id;
        r_last <= wake_last;
        if (accept) begin
            r_tid      <= i_proc_id;
            r_t        <= norm_duration(i_duration);
            r_is_sleep <= (mode == MODE_SLEEP);
            r_all      <= (mode == MODE_WAKE_ALL);
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_tok_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tok_valid <= accept && ((mode == MODE_SLEEP && !full) || mode == MODE_REMOVE);
            r_valid     <= (r_state == ST_WAKE) && wake_now;
            priority case (cmd)
                CMD_INSERT:       r_count <= r_count + CNT_W'(1);
                CMD_DROP, CMD_POP: r_count <= r_count - CNT_W'(1);
                default:          r_count <= r_count;
            endcase
        end
    end

    always_comb begin
        o_bc.cmd      = cmd;
        o_bc.is_sleep = r_is_sleep;
        o_bc.tid      = r_tid;
        // wait left over after the walk past earlier entries
        o_bc.new_t    = i_tok_end.t;
        o_tok.valid   = r_tok_valid;
        o_tok.flag    = 1'b0;
        o_tok.dup     = 1'b0;
        o_tok.rem     = r_count;
        o_tok.t       = r_t;
    end

    assign o_busy     = (r_state != ST_IDLE);
    assign o_valid    = r_valid;
    assign o_woken_id = r_id;
    assign o_last     = r_last;

endmodule

>>> sv/delta_sleep_queue_top.sv
// Delta sleep queue: a row of QUEUE_DEPTH cells plus a sequencer.
// Sleep and remove: busy while the search token walks the cells.
// Tick and wake-all: woken ids are registered out one per cycle once in the wake state;
// an item that wakes nothing frees the block with no strobe. Results cannot stall.
// Synchronous reset empties the queue; cell contents are left as they are.
module delta_sleep_queue_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [dsq_pkg::MODE_W-1:0] i_mode,
    input  logic [dsq_pkg::ID_W-1:0]   i_proc_id,
    input  logic [dsq_pkg::DUR_W-1:0]  i_duration,
    output logic                      o_valid,
    output logic [dsq_pkg::ID_W-1:0]   o_woken_id,
    output logic                      o_last
);
    import dsq_pkg::*;

    t_bcast bc;
    t_token tok_in;
    t_entry w_entry [QUEUE_DEPTH];
    logic   w_at    [QUEUE_DEPTH];
    t_token w_tok   [QUEUE_DEPTH];

    dsq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_mode         (i_mode),
        .i_proc_id      (i_proc_id),
        .i_duration     (i_duration),
        .i_head         (w_entry[0]),
        .i_second_delta (w_entry[1].delta),
        .i_tok_end      (w_tok[QUEUE_DEPTH-1]),
        .o_busy         (busy),
        .o_bc           (bc),
        .o_tok          (tok_in),
        .o_valid        (o_valid),
        .o_woken_id     (o_woken_id),
        .o_last         (o_last)
    );

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry left, right;
        logic   left_at;
        t_token tok;

        if (g == 0) begin : g_head
            assign left    = '0;
            assign left_at = 1'b0;
            assign tok     = tok_in;
        end else begin : g_body
            assign left    = w_entry[g-1];
            assign left_at = w_at[g-1];
            assign tok     = w_tok[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right = '0;
        end else begin : g_inner
            assign right = w_entry[g+1];
        end

        dsq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_first   (g == 0),
            .i_bc      (bc),
            .i_left    (left),
            .i_left_at (left_at),
            .i_right   (right),
            .i_tok     (tok),
            .o_entry   (w_entry[g]),
            .o_at      (w_at[g]),
            .o_tok     (w_tok[g])
        );
    end

endmodule
